FILE: sv/hse_pkg.sv
// Shared types and constants for the heap sort engine.
// No dependencies; every other file in the block refers to this package.
package hse_pkg;

  localparam int DATA_W = 32;

  // Values of the order register.
  localparam logic ORDER_ASC  = 1'b0;
  localparam logic ORDER_DESC = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  is_last;
  } in_t;

  typedef struct packed {
    word_t sorted_value;
    logic  end_of_run;
  } out_t;

  typedef enum logic [1:0] {
    WR_IN,
    WR_V,
    WR_R0,
    WR_CHILD
  } wr_sel_t;

  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    ld_v;
    logic    ld_cl;
    logic    ld_r0;
    logic    right_ok;
    logic    out_load;
    logic    out_end;
  } cmd_t;

  typedef struct packed {
    logic sel_right;
    logic child_wins;
    logic out_busy;
  } status_t;

endpackage

FILE: sv/heap_sort_engine_top.sv
// Top level of the heap sort engine: joins controller and datapath.
// Depends on hse_pkg, hse_ctrl and hse_dp.
//
// Usage:
//   item channel (item_valid/item_ready, item): one signed word per beat,
//   item.is_last closes the run; the DEPTH-th beat closes it regardless.
//   Loading takes one cycle per beat; item_ready is high only while loading.
//   After the closing beat the block heap-sorts in its single-port memory:
//   each sift level reads the left child, reads the right child, then
//   compares and writes; a sift that ends at a leaf adds a closing write,
//   and each sift starts with its own setup states.
//   result channel (result_valid/result_ready, result): the n sorted words
//   in index order, one memory read and one output load per beat,
//   result.end_of_run on the final one. A stalled receiver holds the
//   output register and the drain waits; once the last beat is in the
//   output register the block takes new items again.
//   cfg_we/cfg_wdata writes the order register desc (0 ascending, 1 descending);
//   write it only between runs.
//   Reset (rst, synchronous) empties the run, drops any pending result
//   beat and selects ascending order. The memory needs no clearing.
module heap_sort_engine_top #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  hse_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output hse_pkg::out_t result,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  localparam int IW = $clog2(DEPTH);

  hse_pkg::cmd_t    cmd;
  hse_pkg::status_t st;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;

  // Sequence load, build, extract and drain; hold all indices.
  hse_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_is_last (item.is_last),
    .item_ready   (item_ready),
    .st           (st),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr)
  );

  // Store words, compare children, move the sift value, drive results.
  hse_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .item_value   (item.value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_ready (result_ready),
    .st           (st),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: sv/hse_dp.sv
// Datapath of the heap sort engine: element memory, sift registers,
// comparator, order register and result output register. Uses hse_pkg.
module hse_dp #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  hse_pkg::cmd_t             cmd,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  hse_pkg::word_t            item_value,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      result_ready,
  output hse_pkg::status_t          st,
  output logic                      result_valid,
  output hse_pkg::out_t             result
);

  hse_pkg::word_t mem [DEPTH];
  hse_pkg::word_t rdata;
  hse_pkg::word_t v;
  hse_pkg::word_t cl;
  hse_pkg::word_t r0;
  hse_pkg::word_t chosen;
  hse_pkg::word_t wr_data;
  logic           rok;
  logic           desc;

  // True when a must sit below b in heap order.
  function automatic logic ranks_below(input hse_pkg::word_t a, input hse_pkg::word_t b,
                                       input logic d);
    ranks_below = (d == hse_pkg::ORDER_DESC) ? (a > b) : (a < b);
  endfunction

  always_comb begin
    st.sel_right  = rok && ranks_below(cl, rdata, desc);
    chosen        = st.sel_right ? rdata : cl;
    st.child_wins = ranks_below(v, chosen, desc);
    st.out_busy   = result_valid && !result_ready;
  end

  always_comb begin
    unique case (cmd.wr_sel)
      hse_pkg::WR_IN:    wr_data = item_value;
      hse_pkg::WR_V:     wr_data = v;
      hse_pkg::WR_R0:    wr_data = r0;
      hse_pkg::WR_CHILD: wr_data = chosen;
      default:           wr_data = v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_v) begin
      v <= rdata;
    end
    if (cmd.ld_cl) begin
      cl  <= rdata;
      rok <= cmd.right_ok;
    end
    if (cmd.ld_r0) begin
      r0 <= rdata;
    end
    if (cmd.out_load) begin
      result.sorted_value <= rdata;
      result.end_of_run   <= cmd.out_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc         <= hse_pkg::ORDER_ASC;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        desc <= cfg_wdata;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !result_valid)
    else $error("output register loaded while still holding a beat");

endmodule

FILE: sv/hse_ctrl.sv
// Controller of the heap sort engine: load, heap build, extraction and
// drain sequencing with all index counters. Uses hse_pkg; drives hse_dp.
module hse_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_is_last,
  output logic                      item_ready,
  input  hse_pkg::status_t          st,
  output hse_pkg::cmd_t             cmd,
  output logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [$clog2(DEPTH)-1:0]  wr_addr
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = IW + 2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_BLD_RD,
    S_BLD_V,
    S_EX_R0,
    S_EX_RL,
    S_EX_W,
    S_SF_L,
    S_SF_R,
    S_SF_CMP,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  state_t        state;
  state_t        done_state;
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] i_m1;
  logic [CW-1:0] done_i;
  logic [CW-1:0] size;
  logic [IW-1:0] node;
  logic [IW-1:0] k;
  logic          building;
  logic          done_bld;
  logic [LW-1:0] left;
  logic [LW-1:0] right;
  logic [LW-1:0] size_w;
  logic          left_ok;
  logic          right_ok;
  logic          last_in;
  logic          out_last;

  assign item_ready = (state == S_LOAD);
  assign i_m1       = i - CW'(1);
  assign left       = {1'b0, node, 1'b0} + LW'(1);
  assign right      = left + LW'(1);
  assign size_w     = LW'(size);
  assign left_ok    = left < size_w;
  assign right_ok   = right < size_w;
  assign last_in    = item_is_last || (count == CW'(DEPTH - 1));
  assign out_last   = (CW'(k) + CW'(1)) == n;

  // Where a finished sift goes next.
  always_comb begin
    done_bld = building;
    if (building) begin
      if (i == CW'(1)) begin
        done_bld   = 1'b0;
        done_i     = n;
        done_state = (n == CW'(1)) ? S_OUT_RD : S_EX_R0;
      end else begin
        done_i     = i_m1;
        done_state = S_BLD_RD;
      end
    end else begin
      done_i     = i_m1;
      done_state = (i == CW'(2)) ? S_OUT_RD : S_EX_R0;
    end
  end

  always_comb begin
    cmd     = '0;
    rd_addr = '0;
    wr_addr = '0;
    unique case (state)
      S_LOAD: begin
        cmd.wr_en  = item_valid;
        cmd.wr_sel = hse_pkg::WR_IN;
        wr_addr    = count[IW-1:0];
      end
      S_BLD_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = i_m1[IW-1:0];
      end
      S_BLD_V: begin
        cmd.ld_v = 1'b1;
      end
      S_EX_R0: begin
        cmd.rd_en = 1'b1;
      end
      S_EX_RL: begin
        cmd.ld_r0 = 1'b1;
        cmd.rd_en = 1'b1;
        rd_addr   = i_m1[IW-1:0];
      end
      S_EX_W: begin
        cmd.ld_v   = 1'b1;
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = hse_pkg::WR_R0;
        wr_addr    = i_m1[IW-1:0];
      end
      S_SF_L: begin
        if (left_ok) begin
          cmd.rd_en = 1'b1;
          rd_addr   = left[IW-1:0];
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = hse_pkg::WR_V;
          wr_addr    = node;
        end
      end
      S_SF_R: begin
        cmd.ld_cl    = 1'b1;
        cmd.right_ok = right_ok;
        if (right_ok) begin
          cmd.rd_en = 1'b1;
          rd_addr   = right[IW-1:0];
        end
      end
      S_SF_CMP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = st.child_wins ? hse_pkg::WR_CHILD : hse_pkg::WR_V;
        wr_addr    = node;
      end
      S_OUT_RD: begin
        if (!st.out_busy) begin
          cmd.rd_en = 1'b1;
          rd_addr   = k;
        end
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_end  = out_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      building <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (item_valid) begin
            if (last_in) begin
              n        <= count + CW'(1);
              i        <= count + CW'(1);
              count    <= '0;
              building <= 1'b1;
              state    <= S_BLD_RD;
            end else begin
              count <= count + CW'(1);
            end
          end
        end
        S_BLD_RD: state <= S_BLD_V;
        S_BLD_V: begin
          node  <= i_m1[IW-1:0];
          size  <= n;
          state <= S_SF_L;
        end
        S_EX_R0: state <= S_EX_RL;
        S_EX_RL: state <= S_EX_W;
        S_EX_W: begin
          node  <= '0;
          size  <= i_m1;
          state <= S_SF_L;
        end
        S_SF_L: begin
          if (left_ok) begin
            state <= S_SF_R;
          end else begin
            state    <= done_state;
            i        <= done_i;
            building <= done_bld;
            k        <= '0;
          end
        end
        S_SF_R: state <= S_SF_CMP;
        S_SF_CMP: begin
          if (st.child_wins) begin
            node  <= st.sel_right ? right[IW-1:0] : left[IW-1:0];
            state <= S_SF_L;
          end else begin
            state    <= done_state;
            i        <= done_i;
            building <= done_bld;
            k        <= '0;
          end
        end
        S_OUT_RD: begin
          if (!st.out_busy) begin
            state <= S_OUT_LD;
          end
        end
        S_OUT_LD: begin
          if (out_last) begin
            state <= S_LOAD;
          end else begin
            k     <= k + IW'(1);
            state <= S_OUT_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && item_valid && last_in) |=> (state == S_BLD_RD && n != '0))
    else $error("last beat did not start the sort");

  a_run_size: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (n != '0 && n <= CW'(DEPTH)))
    else $error("run length out of range while sorting");

  a_sift_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_SF_CMP) |-> (LW'(node) < size_w && left_ok))
    else $error("sift compare on a node outside the heap");

endmodule

FILE: tb/heap_sort_engine_top_tb.sv
// Self-checking testbench for heap_sort_engine_top: drives runs of signed words,
// predicts the sorted output in both orders and checks every result beat.
// Depends on hse_pkg and the heap_sort_engine_top RTL.
module heap_sort_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DEPTH      = 64;
  localparam int  HALF_CLK   = 6;
  localparam int  RST_CYCLES = 12;
  localparam int  CYCLE_CAP  = 400000;
  localparam int  SETTLE     = 20;
  localparam int  PHASE_MIN  = 85;
  localparam int  IDLE_PCT   = 33;
  localparam int  SHOW_MAX   = 10;

  localparam hse_pkg::word_t W_MIN = {1'b1, {(hse_pkg::DATA_W-1){1'b0}}};
  localparam hse_pkg::word_t W_MAX = {1'b0, {(hse_pkg::DATA_W-1){1'b1}}};

  // Flavor of the values that go into one random run.
  typedef enum int {
    VAL_WIDE,     // any 32-bit pattern
    VAL_CLUSTER,  // a handful of nearby values, lots of duplicates
    VAL_EDGE      // extremes mixed with wide values
  } val_mix_t;

  logic          clk          = 1'b0;
  logic          rst          = 1'b1;
  logic          item_valid   = 1'b0;
  logic          item_ready;
  hse_pkg::in_t  item         = '0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  hse_pkg::out_t result;
  logic          cfg_we       = 1'b0;
  logic          cfg_wdata    = 1'b0;

  // Words waiting to be driven, and sorted words waiting to come back.
  hse_pkg::in_t  pend_items [$];
  hse_pkg::out_t sorted_due [$];

  // Shadow of the block: element store, fill level and sort order.
  hse_pkg::word_t shadow_store [DEPTH];
  int    shadow_count = 0;
  logic  order_desc   = hse_pkg::ORDER_ASC;

  logic  in_beat      = 1'b0;  // input beat taken at the last rising edge
  logic  calm         = 1'b0;  // no idling on either side while set
  int    pushed_cnt   = 0;
  int    accepted_cnt = 0;
  int    cycle_cnt    = 0;
  int    mismatch_cnt = 0;
  int    beats_checked = 0;
  int    asc_runs     = 0;
  int    desc_runs    = 0;
  int    full_closes  = 0;
  int    longest_run  = 0;

  heap_sort_engine_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always #(HALF_CLK) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sort predictor
  // ---------------------------------------------------------------------------

  // True when a has to sit below b in the heap for the current order.
  function automatic bit sits_below(hse_pkg::word_t a, hse_pkg::word_t b);
    return (order_desc == hse_pkg::ORDER_DESC) ? (a > b) : (a < b);
  endfunction

  function automatic void sift_down(int node, int size);
    int             child;
    hse_pkg::word_t tmp;
    while (2 * node + 1 < size) begin
      child = 2 * node + 1;
      if (child + 1 < size && sits_below(shadow_store[child], shadow_store[child + 1]))
        child++;
      if (!sits_below(shadow_store[node], shadow_store[child]))
        return;
      tmp                 = shadow_store[node];
      shadow_store[node]  = shadow_store[child];
      shadow_store[child] = tmp;
      node                = child;
    end
  endfunction

  // Store one accepted word; on the closing word sort the run and queue
  // every element in index order, end_of_run on the final one.
  function automatic void take_word(hse_pkg::in_t beat);
    int             n;
    hse_pkg::word_t tmp;
    hse_pkg::out_t  exp_beat;
    if (shadow_count >= DEPTH)
      shadow_count = 0;
    shadow_store[shadow_count] = beat.value;
    shadow_count++;
    if (!beat.is_last && shadow_count < DEPTH)
      return;
    if (!beat.is_last)
      full_closes++;
    n = shadow_count;
    // Build the heap bottom-up, then pull the root off one slot at a time.
    for (int i = n; i > 0; i--)
      sift_down(i - 1, n);
    for (int i = n; i > 1; i--) begin
      tmp                 = shadow_store[0];
      shadow_store[0]     = shadow_store[i - 1];
      shadow_store[i - 1] = tmp;
      sift_down(0, i - 1);
    end
    for (int i = 0; i < n; i++) begin
      exp_beat.sorted_value = shadow_store[i];
      exp_beat.end_of_run   = (i == n - 1);
      sorted_due.push_back(exp_beat);
    end
    if (order_desc == hse_pkg::ORDER_DESC)
      desc_runs++;
    else
      asc_runs++;
    if (n > longest_run)
      longest_run = n;
    shadow_count = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next pending word at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || in_beat) begin
      // Only move on once the current beat is gone; hold it otherwise.
      if (pend_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        item_valid <= 1'b1;
        item       <= pend_items.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver side: stall at random, never while calm.
  always @(negedge clk) begin
    if (rst)
      result_ready <= 1'b0;
    else
      result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result beats, then feed input beats to the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hse_pkg::out_t exp_beat;
    in_beat <= !rst && item_valid && item_ready;
    if (rst) begin
      shadow_count = 0;
      order_desc   = hse_pkg::ORDER_ASC;
    end else begin
      if (result_valid && result_ready) begin
        beats_checked++;
        if (sorted_due.size() == 0) begin
          if (mismatch_cnt < SHOW_MAX)
            $display("%0t: unexpected result beat value=%0d end=%0b", $realtime,
                     result.sorted_value, result.end_of_run);
          mismatch_cnt++;
        end else begin
          exp_beat = sorted_due.pop_front();
          if (result.sorted_value !== exp_beat.sorted_value ||
              result.end_of_run !== exp_beat.end_of_run) begin
            if (mismatch_cnt < SHOW_MAX)
              $display("%0t: result beat %0d: expected value=%0d end=%0b, got value=%0d end=%0b",
                       $realtime, beats_checked, exp_beat.sorted_value, exp_beat.end_of_run,
                       result.sorted_value, result.end_of_run);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we)
        order_desc = cfg_wdata;
      if (item_valid && item_ready) begin
        accepted_cnt++;
        take_word(item);
      end
    end
  end

  // Watchdog: give up once the cycle counter passes CYCLE_CAP, counted from the start of simulation.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_cnt, sorted_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(hse_pkg::word_t v, logic last);
    hse_pkg::in_t beat;
    beat.value   = v;
    beat.is_last = last;
    pend_items.push_back(beat);
    pushed_cnt++;
  endtask

  function automatic hse_pkg::word_t pick_word(val_mix_t mix);
    int k;
    case (mix)
      VAL_CLUSTER: begin
        k = $urandom_range(0, 8);
        return hse_pkg::word_t'(k - 4);
      end
      VAL_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return W_MIN;
          1:       return W_MAX;
          2:       return '0;
          3:       return '1;
          default: return hse_pkg::word_t'($urandom);
        endcase
      end
      default: return hse_pkg::word_t'($urandom);
    endcase
  endfunction

  // Queue one run; a full-store run may close without its mark.
  task automatic push_run(int len);
    val_mix_t mix;
    logic     mark;
    mix = val_mix_t'($urandom_range(0, 2));
    for (int i = 0; i < len; i++) begin
      mark = (i == len - 1) && (len < DEPTH || $urandom_range(0, 1));
      push_word(pick_word(mix), mark);
    end
  endtask

  // Queue runs until the phase holds enough words, small runs mostly.
  task automatic push_phase();
    int total;
    int r;
    int len;
    total = 0;
    while (total < PHASE_MIN) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        len = $urandom_range(1, 8);
      else if (r < 93)
        len = $urandom_range(9, 40);
      else
        len = DEPTH;
      push_run(len);
      total += len;
    end
  endtask

  // Hold the sender until every word is in and every result is back.
  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || sorted_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_order(logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed, ascending (reset order): a lone word, then extremes and duplicates.
    push_word('0, 1'b1);
    push_word(W_MAX, 1'b0);
    push_word(W_MIN, 1'b0);
    push_word('1, 1'b0);
    push_word(hse_pkg::word_t'(1), 1'b0);
    push_word('0, 1'b0);
    push_word(W_MIN, 1'b0);
    push_word(W_MAX, 1'b1);
    wait_drained();

    // Directed, descending: alternating bit patterns and a two-word run.
    set_order(hse_pkg::ORDER_DESC);
    push_word(W_MIN, 1'b0);
    push_word(W_MAX, 1'b0);
    push_word(hse_pkg::word_t'(5), 1'b0);
    push_word(hse_pkg::word_t'(5), 1'b0);
    push_word(hse_pkg::word_t'(-5), 1'b0);
    push_word(hse_pkg::word_t'(32'h5555_5555), 1'b0);
    push_word(hse_pkg::word_t'(32'hAAAA_AAAA), 1'b1);
    push_word(W_MAX, 1'b0);
    push_word(W_MIN, 1'b1);
    wait_drained();

    // Random phases: alternate the order over the first four, pick it at random for the last, one phase with no idling.
    for (int p = 0; p < 5; p++) begin
      if (p < 4)
        set_order(p[0] ? hse_pkg::ORDER_DESC : hse_pkg::ORDER_ASC);
      else
        set_order(logic'($urandom_range(0, 1)));
      calm = (p == 2);
      push_phase();
      wait_drained();
    end
    calm = 1'b0;

    $display("covered %0d words in %0d ascending and %0d descending runs, longest %0d words,",
             accepted_cnt, asc_runs, desc_runs, longest_run);
    $display("%0d runs closed by a full store, %0d result beats checked, %0d mismatches",
             full_closes, beats_checked, mismatch_cnt);
    if (mismatch_cnt == 0 && sorted_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: heap_sort_engine_top.f
sv/hse_pkg.sv
sv/hse_dp.sv
sv/hse_ctrl.sv
sv/heap_sort_engine_top.sv
tb/heap_sort_engine_top_tb.sv
